>>> rtl/mrd_pkg.sv
package mrd_pkg;

    // Parser phases, one-hot.
    typedef enum logic [8:0] {
        PH_ADDR    = 9'b0_0000_0001,
        PH_FUNC    = 9'b0_0000_0010,
        PH_RAH     = 9'b0_0000_0100,
        PH_RAL     = 9'b0_0000_1000,
        PH_RVH     = 9'b0_0001_0000,
        PH_RVL     = 9'b0_0010_0000,
        PH_CRCL    = 9'b0_0100_0000,
        PH_CRCH    = 9'b0_1000_0000,
        PH_PAYLOAD = 9'b1_0000_0000
    } phase_t;

    // Event kinds on the result channel.
    localparam logic EVT_BYTE  = 1'b0;
    localparam logic EVT_FRAME = 1'b1;

    localparam logic [7:0]  BROADCAST_ADDR = 8'hFF;
    localparam logic [7:0]  STATION_RESET  = 8'h01;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [8:0]  INDEX_MAX      = 9'd511;
    localparam logic [7:0]  SEEN_MAX       = 8'hFF;

    // Contents of one result word.
    typedef struct packed {
        logic        event_kind;
        logic [7:0]  byte_value;
        logic [8:0]  byte_index;
        logic [7:0]  frame_address;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] register_value;
        logic [7:0]  payload_count;
        logic        has_payload;
        logic        crc_ok;
    } result_t;

endpackage

>>> rtl/mrd_byte_if.sv
interface mrd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_start;

    modport source (output valid, output rx_byte, output burst_start, input ready);
    modport sink (input valid, input rx_byte, input burst_start, output ready);
endinterface

>>> rtl/mrd_event_if.sv
interface mrd_event_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [7:0]  byte_value;
    logic [8:0]  byte_index;
    logic [7:0]  frame_address;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_value;
    logic [7:0]  payload_count;
    logic        has_payload;
    logic        crc_ok;

    modport source (
        output valid, input ready,
        output event_kind, output byte_value, output byte_index,
        output frame_address, output function_code,
        output register_address, output register_value,
        output payload_count, output has_payload, output crc_ok
    );
    modport sink (
        input valid, output ready,
        input event_kind, input byte_value, input byte_index,
        input frame_address, input function_code,
        input register_address, input register_value,
        input payload_count, input has_payload, input crc_ok
    );
endinterface

>>> rtl/mrd_crc16_byte.sv
module mrd_crc16_byte
    import mrd_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    // Reflected CRC16 over one byte: eight shift-and-conditional-xor steps.
    always_comb
    begin
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        crc_out = acc;
    end

endmodule

>>> rtl/modbus_rtu_request_deframer.sv
// Modbus RTU request deframer.
// The rx channel takes one received byte per word, with burst_start set when an
// idle gap on the line came before it; that byte restarts the frame parser.
// The evt channel gives one word per stored frame byte (event_kind 0, with its
// value and saturating index) and one summary word after the CRC high byte
// (event_kind 1, with header fields, byte count and the CRC check). Skipped
// bytes and the CRC low byte give no word.
// A byte's word is registered and shows in the cycle after the byte is accepted.
// Throughput is one byte per cycle while the receiver takes each word; the path
// that sets it is the unrolled eight-step CRC update feeding the running CRC register.
// cfg_wr_en and cfg_wr_data write the own station address (reset value 1);
// write it only while the block is idle.
// Reset clears the parser to wait for an address and empties the result
// register. When the receiver stalls, the result register holds its word and
// rx.ready drops, so no byte is lost while the result waits.
module modbus_rtu_request_deframer
    import mrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    mrd_byte_if.sink    rx,
    mrd_event_if.source evt
);

    logic [7:0]  station_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  haddr_reg, haddr_next;
    logic [7:0]  hfunc_reg, hfunc_next;
    logic [15:0] hra_reg, hra_next;
    logic [15:0] hrv_reg, hrv_next;
    logic [7:0]  hcount_reg, hcount_next;
    logic [7:0]  seen_reg, seen_next;
    logic [8:0]  len_reg, len_next;
    logic [7:0]  crcl_reg, crcl_next;
    logic        pflag_reg, pflag_next;

    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;

    logic        rx_fire;
    logic        restart;
    phase_t      cur_phase;
    logic [15:0] cur_crc;
    logic [7:0]  cur_haddr;
    logic [7:0]  cur_hfunc;
    logic [15:0] cur_hra;
    logic [15:0] cur_hrv;
    logic [7:0]  cur_hcount;
    logic [7:0]  cur_seen;
    logic [8:0]  cur_len;
    logic [7:0]  cur_crcl;
    logic        cur_pflag;
    logic [7:0]  seen_inc;
    logic [15:0] crc_upd;
    logic        emit_store;
    logic        emit_frame;
    logic        crc_match;

    assign rx.ready = !out_valid_reg || evt.ready;
    assign rx_fire  = rx.valid && rx.ready;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= STATION_RESET;
        end
        else if (cfg_wr_en)
        begin
            station_reg <= cfg_wr_data;
        end
    end

    // A burst start or an unused phase code starts the byte from a clean frame.
    assign restart    = rx.burst_start || !(phase_reg inside {PH_ADDR, PH_FUNC, PH_RAH,
                        PH_RAL, PH_RVH, PH_RVL, PH_CRCL, PH_CRCH, PH_PAYLOAD});
    assign cur_phase  = restart ? PH_ADDR  : phase_reg;
    assign cur_crc    = restart ? CRC_INIT : crc_reg;
    assign cur_haddr  = restart ? 8'd0     : haddr_reg;
    assign cur_hfunc  = restart ? 8'd0     : hfunc_reg;
    assign cur_hra    = restart ? 16'd0    : hra_reg;
    assign cur_hrv    = restart ? 16'd0    : hrv_reg;
    assign cur_hcount = restart ? 8'd0     : hcount_reg;
    assign cur_seen   = restart ? 8'd0     : seen_reg;
    assign cur_len    = restart ? 9'd0     : len_reg;
    assign cur_crcl   = restart ? 8'd0     : crcl_reg;
    assign cur_pflag  = restart ? 1'b0     : pflag_reg;

    assign seen_inc  = (cur_seen < SEEN_MAX) ? cur_seen + 8'd1 : cur_seen;
    assign crc_match = ({rx.rx_byte, cur_crcl} == cur_crc);

    mrd_crc16_byte u_crc (
        .crc_in  (cur_crc),
        .data    (rx.rx_byte),
        .crc_out (crc_upd)
    );

    // Frame parser: next state and the result word for this byte.
    always_comb
    begin
        phase_next  = cur_phase;
        crc_next    = cur_crc;
        haddr_next  = cur_haddr;
        hfunc_next  = cur_hfunc;
        hra_next    = cur_hra;
        hrv_next    = cur_hrv;
        hcount_next = cur_hcount;
        seen_next   = cur_seen;
        len_next    = cur_len;
        crcl_next   = cur_crcl;
        pflag_next  = cur_pflag;
        emit_store  = 1'b0;
        emit_frame  = 1'b0;

        case (cur_phase)
            PH_FUNC:
            begin
                hfunc_next = rx.rx_byte;
                phase_next = PH_RAH;
                emit_store = 1'b1;
            end
            PH_RAH:
            begin
                hra_next   = {rx.rx_byte, cur_hra[7:0]};
                phase_next = PH_RAL;
                emit_store = 1'b1;
            end
            PH_RAL:
            begin
                hra_next   = {cur_hra[15:8], rx.rx_byte};
                phase_next = PH_RVH;
                emit_store = 1'b1;
            end
            PH_RVH:
            begin
                hrv_next   = {rx.rx_byte, cur_hrv[7:0]};
                phase_next = PH_RVL;
                emit_store = 1'b1;
            end
            PH_RVL:
            begin
                hrv_next   = {cur_hrv[15:8], rx.rx_byte};
                phase_next = PH_CRCL;
                emit_store = 1'b1;
            end
            PH_CRCL:
            begin
                // A byte equal to twice the register value is a byte count.
                if ({9'd0, rx.rx_byte} == {cur_hrv, 1'b0})
                begin
                    if (!cur_pflag)
                    begin
                        hcount_next = rx.rx_byte;
                        pflag_next  = 1'b1;
                    end
                    seen_next  = 8'd0;
                    phase_next = PH_PAYLOAD;
                    emit_store = 1'b1;
                end
                else
                begin
                    crcl_next  = rx.rx_byte;
                    phase_next = PH_CRCH;
                end
            end
            PH_PAYLOAD:
            begin
                seen_next = seen_inc;
                if (seen_inc >= cur_hcount)
                begin
                    phase_next = PH_CRCL;
                end
                emit_store = 1'b1;
            end
            PH_CRCH:
            begin
                emit_frame  = 1'b1;
                phase_next  = PH_ADDR;
                crc_next    = CRC_INIT;
                haddr_next  = 8'd0;
                hfunc_next  = 8'd0;
                hra_next    = 16'd0;
                hrv_next    = 16'd0;
                hcount_next = 8'd0;
                seen_next   = 8'd0;
                len_next    = 9'd0;
                crcl_next   = 8'd0;
                pflag_next  = 1'b0;
            end
            default:
            begin
                // Waiting for our own address or the broadcast address.
                if (rx.rx_byte == station_reg || rx.rx_byte == BROADCAST_ADDR)
                begin
                    haddr_next = rx.rx_byte;
                    phase_next = PH_FUNC;
                    emit_store = 1'b1;
                end
            end
        endcase

        // Every stored byte runs through the CRC and advances the index, which saturates at INDEX_MAX.
        if (emit_store)
        begin
            crc_next = crc_upd;
            if (cur_len < INDEX_MAX)
            begin
                len_next = cur_len + 9'd1;
            end
        end

        res_next = '0;
        if (emit_frame)
        begin
            res_next.event_kind       = EVT_FRAME;
            res_next.frame_address    = cur_haddr;
            res_next.function_code    = cur_hfunc;
            res_next.register_address = cur_hra;
            res_next.register_value   = cur_hrv;
            res_next.payload_count    = cur_pflag ? cur_hcount : 8'd0;
            res_next.has_payload      = cur_pflag;
            res_next.crc_ok           = crc_match;
        end
        else
        begin
            res_next.event_kind = EVT_BYTE;
            res_next.byte_value = rx.rx_byte;
            res_next.byte_index = cur_len;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ADDR;
            crc_reg    <= CRC_INIT;
            haddr_reg  <= 8'd0;
            hfunc_reg  <= 8'd0;
            hra_reg    <= 16'd0;
            hrv_reg    <= 16'd0;
            hcount_reg <= 8'd0;
            seen_reg   <= 8'd0;
            len_reg    <= 9'd0;
            crcl_reg   <= 8'd0;
            pflag_reg  <= 1'b0;
        end
        else if (rx_fire)
        begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            haddr_reg  <= haddr_next;
            hfunc_reg  <= hfunc_next;
            hra_reg    <= hra_next;
            hrv_reg    <= hrv_next;
            hcount_reg <= hcount_next;
            seen_reg   <= seen_next;
            len_reg    <= len_next;
            crcl_reg   <= crcl_next;
            pflag_reg  <= pflag_next;
        end
    end

    // Result register valid: set by a byte that gives a word, cleared when taken.
    always_comb
    begin
        if (rx_fire && (emit_store || emit_frame))
        begin
            out_valid_next = 1'b1;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded only with a new word.
    always_ff @(posedge clk)
    begin
        if (rx_fire && (emit_store || emit_frame))
        begin
            res_reg <= res_next;
        end
    end

    assign evt.valid            = out_valid_reg;
    assign evt.event_kind       = res_reg.event_kind;
    assign evt.byte_value       = res_reg.byte_value;
    assign evt.byte_index       = res_reg.byte_index;
    assign evt.frame_address    = res_reg.frame_address;
    assign evt.function_code    = res_reg.function_code;
    assign evt.register_address = res_reg.register_address;
    assign evt.register_value   = res_reg.register_value;
    assign evt.payload_count    = res_reg.payload_count;
    assign evt.has_payload      = res_reg.has_payload;
    assign evt.crc_ok           = res_reg.crc_ok;

endmodule

>>> test/modbus_rtu_request_deframer_tb.sv
module modbus_rtu_request_deframer_tb
    import mrd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // How a row of the directed table is checked.
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_BYTE
    } check_t;

    typedef struct packed {
        logic [7:0] value;
        logic       burst;
        check_t     check;
        logic [8:0] index;
    } row_t;

    localparam int DIRECTED_ROWS  = 23;
    localparam int PHASES         = 4;
    localparam int PHASE_BYTES    = 390;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [7:0] cfg_wr_data;

    mrd_byte_if  rx ();
    mrd_event_if evt ();

    modbus_rtu_request_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (rx),
        .evt         (evt)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idling of each side for the current phase, in percent.
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned gap_by_phase[PHASES]   = '{0, 56, 0, 21};
    int unsigned stall_by_phase[PHASES] = '{0, 0, 56, 21};

    result_t     expected_events[$];
    result_t     oldest_event;
    int unsigned errors;
    int unsigned frame_bytes;
    int unsigned quiet_cycles;
    row_t        directed_rows[DIRECTED_ROWS];

    // Own copy of the deframer state.
    logic [7:0]  station;
    phase_t      parse_phase;
    logic [15:0] running_crc;
    logic [7:0]  held_addr;
    logic [7:0]  held_func;
    logic [15:0] held_reg_addr;
    logic [15:0] held_reg_value;
    logic [7:0]  held_count;
    logic [7:0]  seen_count;
    logic [8:0]  frame_len;
    logic [7:0]  crc_low;
    logic        payload_flag;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic row_t stim_row(input logic [7:0] value, input logic burst,
                                      input check_t check, input logic [8:0] index);
        row_t r;
        r.value = value;
        r.burst = burst;
        r.check = check;
        r.index = index;
        return r;
    endfunction

    task automatic restart_parser();
        parse_phase    = PH_ADDR;
        running_crc    = CRC_INIT;
        held_addr      = 8'h00;
        held_func      = 8'h00;
        held_reg_addr  = 16'h0000;
        held_reg_value = 16'h0000;
        held_count     = 8'h00;
        seen_count     = 8'h00;
        frame_len      = 9'd0;
        crc_low        = 8'h00;
        payload_flag   = 1'b0;
    endtask

    // A stored byte is reported with its index and folded into the CRC.
    task automatic record_frame_byte(input logic [7:0] b, output logic emit, output result_t ev);
        ev = '0;
        ev.event_kind = EVT_BYTE;
        ev.byte_value = b;
        ev.byte_index = frame_len;
        emit = 1'b1;
        running_crc = crc16_step(running_crc, b);
        if (frame_len < INDEX_MAX)
        begin
            frame_len = frame_len + 9'd1;
        end
    endtask

    // Advances the parser by one received byte and gives the word it causes.
    task automatic deframe_byte(input logic [7:0] b, input logic burst,
                                output logic emit, output result_t ev);
        logic [15:0] rx_crc;
        emit = 1'b0;
        ev = '0;
        if (burst)
        begin
            restart_parser();
        end
        case (parse_phase)
            PH_FUNC:
            begin
                held_func = b;
                parse_phase = PH_RAH;
                record_frame_byte(b, emit, ev);
            end
            PH_RAH:
            begin
                held_reg_addr[15:8] = b;
                parse_phase = PH_RAL;
                record_frame_byte(b, emit, ev);
            end
            PH_RAL:
            begin
                held_reg_addr[7:0] = b;
                parse_phase = PH_RVH;
                record_frame_byte(b, emit, ev);
            end
            PH_RVH:
            begin
                held_reg_value[15:8] = b;
                parse_phase = PH_RVL;
                record_frame_byte(b, emit, ev);
            end
            PH_RVL:
            begin
                held_reg_value[7:0] = b;
                parse_phase = PH_CRCL;
                record_frame_byte(b, emit, ev);
            end
            PH_CRCL:
            begin
                // A byte equal to twice the register value is a byte count.
                if (32'(b) == 32'(held_reg_value) * 2)
                begin
                    if (!payload_flag)
                    begin
                        held_count = b;
                        payload_flag = 1'b1;
                    end
                    seen_count = 8'h00;
                    parse_phase = PH_PAYLOAD;
                    record_frame_byte(b, emit, ev);
                end
                else
                begin
                    crc_low = b;
                    parse_phase = PH_CRCH;
                end
            end
            PH_PAYLOAD:
            begin
                if (seen_count < SEEN_MAX)
                begin
                    seen_count = seen_count + 8'd1;
                end
                if (seen_count >= held_count)
                begin
                    parse_phase = PH_CRCL;
                end
                record_frame_byte(b, emit, ev);
            end
            PH_CRCH:
            begin
                rx_crc = {b, crc_low};
                ev.event_kind       = EVT_FRAME;
                ev.frame_address    = held_addr;
                ev.function_code    = held_func;
                ev.register_address = held_reg_addr;
                ev.register_value   = held_reg_value;
                ev.payload_count    = payload_flag ? held_count : 8'h00;
                ev.has_payload      = payload_flag;
                ev.crc_ok           = (rx_crc == running_crc);
                emit = 1'b1;
                restart_parser();
            end
            default:
            begin
                if (parse_phase != PH_ADDR)
                begin
                    restart_parser();
                end
                if (b == station || b == BROADCAST_ADDR)
                begin
                    held_addr = b;
                    parse_phase = PH_FUNC;
                    record_frame_byte(b, emit, ev);
                end
            end
        endcase
    endtask

    // Offers one byte, waits for it to be taken and queues the word it should cause.
    task automatic put_byte(input logic [7:0] b, input logic burst,
                            input check_t check, input logic [8:0] index);
        logic    emit;
        result_t ev;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        rx.valid       <= 1'b1;
        rx.rx_byte     <= b;
        rx.burst_start <= burst;
        @(posedge clk);
        while (!rx.ready)
        begin
            @(posedge clk);
        end
        deframe_byte(b, burst, emit, ev);
        if (check == CHK_NONE)
        begin
            emit = 1'b0;
        end
        else if (check == CHK_BYTE)
        begin
            emit = 1'b1;
            ev = '0;
            ev.event_kind = EVT_BYTE;
            ev.byte_value = b;
            ev.byte_index = index;
        end
        if (emit)
        begin
            expected_events.push_back(ev);
        end
    endtask

    // Mostly well-formed requests with random content; some carry payloads,
    // some have a bad CRC, some are cut short or broken by a restart.
    task automatic send_random_frame(input bit long_frame);
        logic [7:0]  bytes_out[$];
        logic [7:0]  addr_byte;
        logic [15:0] reg_addr;
        logic [15:0] reg_value;
        logic [15:0] crc;
        bit          payload;
        int          reps;
        int          plen;
        int          stop_at;
        int          pick;
        if ($urandom_range(7) == 0)
        begin
            repeat ($urandom_range(3, 1))
            begin
                put_byte(8'($urandom_range(255)), 1'($urandom_range(1)), CHK_PREDICT, 9'd0);
            end
        end

        pick = $urandom_range(9);
        if (long_frame || pick < 7)
            addr_byte = station;
        else if (pick < 9)
            addr_byte = BROADCAST_ADDR;
        else
            addr_byte = 8'($urandom_range(255));

        reg_addr = 16'($urandom_range(65535));
        if ($urandom_range(7) == 0)
        begin
            reg_addr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end

        payload = long_frame || ($urandom_range(2) == 0);
        if (long_frame)
            reg_value = 16'd127;
        else if (payload)
            reg_value = 16'(($urandom_range(15) == 0) ? $urandom_range(127) : $urandom_range(4));
        else if ($urandom_range(7) == 0)
            reg_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else
            reg_value = 16'($urandom_range(65535));

        bytes_out.push_back(addr_byte);
        bytes_out.push_back(8'($urandom_range(255)));
        bytes_out.push_back(reg_addr[15:8]);
        bytes_out.push_back(reg_addr[7:0]);
        bytes_out.push_back(reg_value[15:8]);
        bytes_out.push_back(reg_value[7:0]);

        // Byte count then payload, sometimes repeated; a zero count still takes one byte.
        if (payload)
        begin
            reps = (long_frame || $urandom_range(3) == 0) ? 2 : 1;
            plen = (reg_value == 16'd0) ? 1 : 2 * int'(reg_value);
            repeat (reps)
            begin
                bytes_out.push_back(8'(2 * reg_value));
                repeat (plen)
                begin
                    bytes_out.push_back(8'($urandom_range(255)));
                end
            end
        end

        crc = CRC_INIT;
        foreach (bytes_out[i])
        begin
            crc = crc16_step(crc, bytes_out[i]);
        end
        if ($urandom_range(7) == 0)
        begin
            crc = crc ^ 16'(1 << $urandom_range(15));
        end
        bytes_out.push_back(crc[7:0]);
        bytes_out.push_back(crc[15:8]);

        stop_at = bytes_out.size();
        if (!long_frame && $urandom_range(9) == 0)
        begin
            stop_at = $urandom_range(bytes_out.size() - 1, 1);
        end
        for (int i = 0; i < stop_at; i++)
        begin
            put_byte(bytes_out[i],
                     (i == 0) ? 1'(long_frame || $urandom_range(3) != 0)
                              : 1'($urandom_range(199) == 0),
                     CHK_PREDICT, 9'd0);
        end
        frame_bytes += stop_at;
    endtask

    // Lets every expected word arrive, then waits out the byte that
    // gives no word.
    task automatic wait_drained();
        rx.valid <= 1'b0;
        while (expected_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_station(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        station = value;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Stimulus and the phases of idling and station address.
    initial
    begin
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= 8'h00;
        rx.valid       <= 1'b0;
        rx.rx_byte     <= 8'h00;
        rx.burst_start <= 1'b0;
        errors = 0;
        gap_pct = 0;
        stall_pct = 0;
        station = STATION_RESET;
        restart_parser();

        // Skipped byte, broadcast, restart mid-frame, a plain read request with a
        // good CRC, then a zero byte count with a repeated count.
        directed_rows = '{
            stim_row(8'h00, 1'b1, CHK_NONE,    9'd0),
            stim_row(8'hFF, 1'b0, CHK_BYTE,    9'd0),
            stim_row(8'h10, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h01, 1'b1, CHK_BYTE,    9'd0),
            stim_row(8'h03, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h00, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h00, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h00, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h01, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h84, 1'b0, CHK_NONE,    9'd0),
            stim_row(8'h0A, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h01, 1'b1, CHK_BYTE,    9'd0),
            stim_row(8'h10, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'hFF, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'hFF, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h00, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h00, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h00, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'hAB, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h00, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'hCD, 1'b0, CHK_PREDICT, 9'd0),
            stim_row(8'h12, 1'b0, CHK_NONE,    9'd0),
            stim_row(8'h34, 1'b0, CHK_PREDICT, 9'd0)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            gap_pct = gap_by_phase[p];
            stall_pct = stall_by_phase[p];
            case (p)
                1: write_station(8'h00);
                2: write_station(8'hFF);
                3: write_station(8'($urandom_range(255)));
                default: ;
            endcase
            frame_bytes = 0;
            if (p == 0)
            begin
                foreach (directed_rows[i])
                begin
                    put_byte(directed_rows[i].value, directed_rows[i].burst,
                             directed_rows[i].check, directed_rows[i].index);
                end
                // One frame long enough for the index to saturate.
                send_random_frame(1'b1);
            end
            while (frame_bytes < PHASE_BYTES)
            begin
                send_random_frame(1'b0);
            end
            wait_drained();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // The receiver stalls at random.
    initial
    begin
        evt.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            evt.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Each word taken from the block is held against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && evt.valid && evt.ready)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected word, kind %0d value %0h index %0d",
                         $time, evt.event_kind, evt.byte_value, evt.byte_index);
                errors++;
            end
            else
            begin
                oldest_event = expected_events.pop_front();
                check_field("event_kind", oldest_event.event_kind, evt.event_kind);
                check_field("byte_value", oldest_event.byte_value, evt.byte_value);
                check_field("byte_index", oldest_event.byte_index, evt.byte_index);
                check_field("frame_address", oldest_event.frame_address, evt.frame_address);
                check_field("function_code", oldest_event.function_code, evt.function_code);
                check_field("register_address", oldest_event.register_address,
                            evt.register_address);
                check_field("register_value", oldest_event.register_value,
                            evt.register_value);
                check_field("payload_count", oldest_event.payload_count, evt.payload_count);
                check_field("has_payload", oldest_event.has_payload, evt.has_payload);
                check_field("crc_ok", oldest_event.crc_ok, evt.crc_ok);
            end
        end
    end

    // Ends the run if neither channel has moved a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (rx.valid && rx.ready) || (evt.valid && evt.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
